### rtl/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int QUAT_WIDTH  = 16;

  localparam int QW   = 36;
  localparam int FRAC = 30;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t ONE_Q     = q_t'(64'd1 << FRAC);
  localparam q_t PI_Q      = q_t'(64'd3373259426);
  localparam q_t HALF_PI_Q = q_t'(64'd1686629713);

  localparam int SC_LAT  = 14;
  localparam int CMB_LAT = 3;

  // Q.30 product, rounded half away from zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [QW-1:0]   ma;
    logic [QW-1:0]   mb;
    logic [2*QW-1:0] p;
    q_t              r;
    ma = a[QW-1] ? QW'(-a) : QW'(a);
    mb = b[QW-1] ? QW'(-b) : QW'(b);
    p  = ma * mb + ((2*QW)'(1) << (FRAC - 1));
    r  = q_t'(p[QW+FRAC-1:FRAC]);
    return (a[QW-1] ^ b[QW-1]) ? -r : r;
  endfunction

endpackage
`default_nettype wire

### rtl/e2q_if.sv
`default_nettype none
interface e2q_angle_if #(parameter int W = e2q_pkg::ANGLE_WIDTH);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] roll_angle;
  logic signed [W-1:0] pitch_angle;
  logic signed [W-1:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if #(parameter int W = e2q_pkg::QUAT_WIDTH);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

### rtl/euler_to_quaternion.sv
`default_nettype none
// ZYX Euler angles (roll, pitch, yaw; signed Q3.(ANGLE_WIDTH-3) radians) to a unit
// quaternion (signed Q2.(QUAT_WIDTH-2), clamped to +/-1.0). Fully pipelined: one
// transfer per cycle in and out; the result passes through the 14-stage half-angle
// sine/cosine polynomial and then the 3-stage product/round stage. A stall on the
// output freezes the whole pipe; nothing is lost or repeated.
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH,
  parameter int QUAT_WIDTH  = e2q_pkg::QUAT_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  e2q_angle_if.sink  angles,
  e2q_quat_if.source quat
);

  localparam int LAT = e2q_pkg::SC_LAT + e2q_pkg::CMB_LAT;

  logic        en;
  logic [LAT-1:0] vld;
  e2q_pkg::q_t sr, cr, sp, cp, sy, cy;

  assign en           = !vld[LAT-1] || quat.ready;
  assign angles.ready = en;
  assign quat.valid   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angles.valid};
    end
  end

  e2q_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk(clk), .en(en), .angle(angles.roll_angle), .sin_h(sr), .cos_h(cr)
  );

  e2q_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk(clk), .en(en), .angle(angles.pitch_angle), .sin_h(sp), .cos_h(cp)
  );

  e2q_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk(clk), .en(en), .angle(angles.yaw_angle), .sin_h(sy), .cos_h(cy)
  );

  e2q_combine #(.QUAT_WIDTH(QUAT_WIDTH)) u_combine (
    .clk(clk), .en(en),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .quat_w(quat.quat_w), .quat_x(quat.quat_x),
    .quat_y(quat.quat_y), .quat_z(quat.quat_z)
  );

endmodule
`default_nettype wire

### rtl/e2q_sincos.sv
`default_nettype none
module e2q_sincos #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle,
  output e2q_pkg::q_t                        sin_h,
  output e2q_pkg::q_t                        cos_h
);

  localparam int DIV_S = 41;
  localparam int NSTEP = 6;
  localparam longint unsigned SIN_D [NSTEP] = '{110, 72, 42, 20, 6, 1};
  localparam longint unsigned COS_D [NSTEP] = '{132, 90, 56, 30, 12, 2};

  e2q_pkg::q_t h_full;
  e2q_pkg::q_t hf;
  logic        ff;
  e2q_pkg::q_t x2r;
  e2q_pkg::q_t h1;
  logic        f1;

  e2q_pkg::q_t pa_s [NSTEP];
  e2q_pkg::q_t pa_c [NSTEP];
  e2q_pkg::q_t xa   [NSTEP];
  e2q_pkg::q_t ha   [NSTEP];
  logic        fa   [NSTEP];
  e2q_pkg::q_t tb_s [NSTEP];
  e2q_pkg::q_t tb_c [NSTEP];
  e2q_pkg::q_t xb   [NSTEP];
  e2q_pkg::q_t hb   [NSTEP];
  logic        fb   [NSTEP];

  assign h_full = e2q_pkg::q_t'(e2q_pkg::q_t'(angle) <<< (32 - ANGLE_WIDTH));

  always_ff @(posedge clk) begin
    if (en) begin
      if (h_full > e2q_pkg::HALF_PI_Q) begin
        hf <= e2q_pkg::PI_Q - h_full;
        ff <= 1'b1;
      end else if (h_full < -e2q_pkg::HALF_PI_Q) begin
        hf <= -e2q_pkg::PI_Q - h_full;
        ff <= 1'b1;
      end else begin
        hf <= h_full;
        ff <= 1'b0;
      end
      x2r <= e2q_pkg::qmul(hf, hf);
      h1  <= hf;
      f1  <= ff;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam longint unsigned MS = ((64'd1 << DIV_S) + SIN_D[j] - 64'd1) / SIN_D[j];
    localparam longint unsigned MC = ((64'd1 << DIV_S) + COS_D[j] - 64'd1) / COS_D[j];
    e2q_pkg::q_t x_in;
    e2q_pkg::q_t h_in;
    logic        f_in;
    e2q_pkg::q_t ts_in;
    e2q_pkg::q_t tc_in;
    logic [73:0] dps;
    logic [73:0] dpc;

    if (j == 0) begin : g_first
      // unit factor: the first product passes x^2 through exactly
      assign x_in  = x2r;
      assign h_in  = h1;
      assign f_in  = f1;
      assign ts_in = e2q_pkg::ONE_Q;
      assign tc_in = e2q_pkg::ONE_Q;
    end else begin : g_next
      assign x_in  = xb[j-1];
      assign h_in  = hb[j-1];
      assign f_in  = fb[j-1];
      assign ts_in = tb_s[j-1];
      assign tc_in = tb_c[j-1];
    end

    assign dps = 74'(pa_s[j][32:0]) * 74'(MS[40:0]);
    assign dpc = 74'(pa_c[j][32:0]) * 74'(MC[40:0]);

    always_ff @(posedge clk) begin
      if (en) begin
        xa[j] <= x_in;
        ha[j] <= h_in;
        fa[j] <= f_in;
        pa_c[j] <= e2q_pkg::qmul(x_in, tc_in);
        if (j == NSTEP - 1) begin
          pa_s[j] <= e2q_pkg::qmul(h_in, ts_in);
        end else begin
          pa_s[j] <= e2q_pkg::qmul(x_in, ts_in);
        end
        xb[j] <= xa[j];
        hb[j] <= ha[j];
        fb[j] <= fa[j];
        tb_c[j] <= e2q_pkg::ONE_Q - e2q_pkg::q_t'(dpc[73:DIV_S]);
        if (j == NSTEP - 1) begin
          tb_s[j] <= pa_s[j];
        end else begin
          tb_s[j] <= e2q_pkg::ONE_Q - e2q_pkg::q_t'(dps[73:DIV_S]);
        end
      end
    end
  end

  assign sin_h = tb_s[NSTEP-1];
  assign cos_h = fb[NSTEP-1] ? -tb_c[NSTEP-1] : tb_c[NSTEP-1];

endmodule
`default_nettype wire

### rtl/e2q_combine.sv
`default_nettype none
module e2q_combine #(
  parameter int QUAT_WIDTH = e2q_pkg::QUAT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire e2q_pkg::q_t                  sr,
  input  wire e2q_pkg::q_t                  cr,
  input  wire e2q_pkg::q_t                  sp,
  input  wire e2q_pkg::q_t                  cp,
  input  wire e2q_pkg::q_t                  sy,
  input  wire e2q_pkg::q_t                  cy,
  output logic signed [QUAT_WIDTH-1:0]      quat_w,
  output logic signed [QUAT_WIDTH-1:0]      quat_x,
  output logic signed [QUAT_WIDTH-1:0]      quat_y,
  output logic signed [QUAT_WIDTH-1:0]      quat_z
);

  localparam int SH = 32 - QUAT_WIDTH;
  localparam e2q_pkg::q_t LIM = e2q_pkg::q_t'(64'd1 << (QUAT_WIDTH - 2));

  e2q_pkg::q_t pa, pb, pc, pd, cy1, sy1;
  e2q_pkg::q_t t [8];
  e2q_pkg::q_t sum [4];
  logic signed [QUAT_WIDTH-1:0] res [4];

  always_ff @(posedge clk) begin
    if (en) begin
      pa  <= e2q_pkg::qmul(cr, cp);
      pb  <= e2q_pkg::qmul(sr, sp);
      pc  <= e2q_pkg::qmul(sr, cp);
      pd  <= e2q_pkg::qmul(cr, sp);
      cy1 <= cy;
      sy1 <= sy;
      t[0] <= e2q_pkg::qmul(pa, cy1);
      t[1] <= e2q_pkg::qmul(pb, sy1);
      t[2] <= e2q_pkg::qmul(pc, cy1);
      t[3] <= e2q_pkg::qmul(pd, sy1);
      t[4] <= e2q_pkg::qmul(pd, cy1);
      t[5] <= e2q_pkg::qmul(pc, sy1);
      t[6] <= e2q_pkg::qmul(pa, sy1);
      t[7] <= e2q_pkg::qmul(pb, cy1);
      quat_w <= res[0];
      quat_x <= res[1];
      quat_y <= res[2];
      quat_z <= res[3];
    end
  end

  assign sum[0] = t[0] + t[1];
  assign sum[1] = t[2] - t[3];
  assign sum[2] = t[4] + t[5];
  assign sum[3] = t[6] - t[7];

  for (genvar k = 0; k < 4; k++) begin : g_out
    logic [e2q_pkg::QW-1:0] mag;
    logic [e2q_pkg::QW-1:0] mag_r;
    e2q_pkg::q_t            r;
    assign mag = sum[k][e2q_pkg::QW-1] ? e2q_pkg::QW'(-sum[k]) : e2q_pkg::QW'(sum[k]);
    if (SH == 0) begin : g_nr
      assign mag_r = mag;
    end else begin : g_rnd
      assign mag_r = (mag + (e2q_pkg::QW'(1) << (SH - 1))) >> SH;
    end
    assign r = sum[k][e2q_pkg::QW-1] ? -e2q_pkg::q_t'(mag_r) : e2q_pkg::q_t'(mag_r);
    always_comb begin
      if (r > LIM) begin
        res[k] = QUAT_WIDTH'(LIM);
      end else if (r < -LIM) begin
        res[k] = QUAT_WIDTH'(-LIM);
      end else begin
        res[k] = QUAT_WIDTH'(r);
      end
    end
  end

endmodule
`default_nettype wire

### sim/e2q_checker.sv
`timescale 1ns / 1ps
module e2q_checker (
  input wire logic clk,
  input wire logic rst,
  e2q_angle_if.sink  angles,
  e2q_quat_if.sink   quat,
  output int         errors,
  output int         pending,
  output int         n_out
);

  typedef longint signed s64;
  typedef struct packed {
    logic signed [e2q_pkg::QUAT_WIDTH-1:0] w;
    logic signed [e2q_pkg::QUAT_WIDTH-1:0] x;
    logic signed [e2q_pkg::QUAT_WIDTH-1:0] y;
    logic signed [e2q_pkg::QUAT_WIDTH-1:0] z;
  } quat_t;

  quat_t expected_quats[$];

  localparam s64 ONE = s64'(1) << 30;
  localparam s64 PI = 64'sd3373259426;
  localparam s64 HPI = 64'sd1686629713;

  function automatic s64 fx_mul(s64 a, s64 b);
    logic neg;
    longint unsigned ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -s64'(p) : s64'(p);
  endfunction

  function automatic void half_sin_cos(logic signed [e2q_pkg::ANGLE_WIDTH-1:0] ang,
                                       output s64 s, output s64 c);
    s64 h, x2, t;
    logic flip;
    h = s64'(ang) * (s64'(1) << (32 - e2q_pkg::ANGLE_WIDTH));
    flip = 0;
    if (h > HPI) begin
      h = PI - h;
      flip = 1;
    end else if (h < -HPI) begin
      h = -PI - h;
      flip = 1;
    end
    x2 = fx_mul(h, h);
    t = ONE - x2 / 110;
    t = ONE - fx_mul(x2, t) / 72;
    t = ONE - fx_mul(x2, t) / 42;
    t = ONE - fx_mul(x2, t) / 20;
    t = ONE - fx_mul(x2, t) / 6;
    s = fx_mul(h, t);
    t = ONE - x2 / 132;
    t = ONE - fx_mul(x2, t) / 90;
    t = ONE - fx_mul(x2, t) / 56;
    t = ONE - fx_mul(x2, t) / 30;
    t = ONE - fx_mul(x2, t) / 12;
    t = ONE - fx_mul(x2, t) / 2;
    c = flip ? -t : t;
  endfunction

  function automatic logic signed [e2q_pkg::QUAT_WIDTH-1:0] round_clamp(s64 v);
    s64 lim, r;
    longint unsigned m;
    int sh;
    sh = 32 - e2q_pkg::QUAT_WIDTH;
    lim = s64'(1) << (e2q_pkg::QUAT_WIDTH - 2);
    m = v < 0 ? -v : v;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    r = v < 0 ? -s64'(m) : s64'(m);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[e2q_pkg::QUAT_WIDTH-1:0];
  endfunction

  function automatic s64 prod3(s64 a, s64 b, s64 c);
    return fx_mul(fx_mul(a, b), c);
  endfunction

  function automatic quat_t zyx_quat(logic signed [e2q_pkg::ANGLE_WIDTH-1:0] r,
                                     logic signed [e2q_pkg::ANGLE_WIDTH-1:0] p,
                                     logic signed [e2q_pkg::ANGLE_WIDTH-1:0] y);
    s64 sr, cr, sp, cp, sy, cy;
    quat_t q;
    half_sin_cos(r, sr, cr);
    half_sin_cos(p, sp, cp);
    half_sin_cos(y, sy, cy);
    q.w = round_clamp(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = round_clamp(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = round_clamp(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = round_clamp(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  task automatic report(string what, int got, int exp);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    quat_t e;
    if (!rst) begin
      if (angles.valid && angles.ready)
        expected_quats.push_back(zyx_quat(angles.roll_angle, angles.pitch_angle,
                                          angles.yaw_angle));
      if (quat.valid && quat.ready) begin
        n_out++;
        if (expected_quats.size() == 0) begin
          report("unexpected transfer, w", quat.quat_w, 0);
        end else begin
          e = expected_quats.pop_front();
          if (quat.quat_w !== e.w) report("quat_w", quat.quat_w, e.w);
          if (quat.quat_x !== e.x) report("quat_x", quat.quat_x, e.x);
          if (quat.quat_y !== e.y) report("quat_y", quat.quat_y, e.y);
          if (quat.quat_z !== e.z) report("quat_z", quat.quat_z, e.z);
        end
      end
    end
    pending = expected_quats.size();
  end
endmodule

### sim/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps
module euler_to_quaternion_tb;

  logic clk = 0;
  logic rst = 1;
  int errors, pending, n_out;
  int hold_cycles = 0;
  int long_cycles = 0;
  logic long_hold = 0;

  e2q_angle_if angles ();
  e2q_quat_if  quat ();

  euler_to_quaternion i_dut (.clk(clk), .rst(rst), .angles(angles), .quat(quat));
  e2q_checker i_chk (.clk(clk), .rst(rst), .angles(angles), .quat(quat),
                     .errors(errors), .pending(pending), .n_out(n_out));

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 51472)) - 16'd25736;
    if (r < 9) return 16'($urandom);
    return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
  endfunction

  task automatic send(logic [15:0] r, logic [15:0] p, logic [15:0] y);
    angles.valid <= 1;
    angles.roll_angle <= r;
    angles.pitch_angle <= p;
    angles.yaw_angle <= y;
    do @(posedge clk); while (!angles.ready);
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      angles.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off while long_hold is set
  always @(posedge clk) begin
    if (rst) begin
      quat.ready <= 0;
    end else if (long_hold && long_cycles < 100) begin
      long_cycles <= long_cycles + 1;
      quat.ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      quat.ready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_cycles <= gap_len();
      quat.ready <= 0;
    end else begin
      quat.ready <= 1;
    end
  end

  initial begin
    logic [15:0] dir[14];
    int i;
    angles.valid = 0;
    angles.roll_angle = 0;
    angles.pitch_angle = 0;
    angles.yaw_angle = 0;
    dir = '{16'd0, 16'd25736, -16'sd25736, 16'h7fff, 16'h8000, 16'd12868,
            -16'sd12868, 16'd1, 16'hffff, 16'd6434, 16'd19302, -16'sd19302,
            16'd25735, 16'd8192};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (i = 0; i < 14; i++) send(dir[i], 0, 0);
    for (i = 0; i < 14; i++) send(0, dir[i], dir[13 - i]);
    send(16'h7fff, 16'h8000, 16'h7fff);
    send(16'h8000, 16'h7fff, 16'h8000);
    // long receiver hold-off while input keeps being offered
    long_hold <= 1;
    for (i = 0; i < 60; i++) send(rand_angle(), rand_angle(), rand_angle());
    angles.valid <= 0;
    repeat (30) @(posedge clk);
    long_hold <= 0;
    for (i = 0; i < 360; i++) begin
      send(rand_angle(), rand_angle(), rand_angle());
      if (i == 150) begin
        angles.valid <= 0;
        while (pending != 0) @(posedge clk);
      end else begin
        idle_gap();
      end
    end
    angles.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent 450 attitudes (directed extremes, out-of-range and random), %0d checked",
             n_out);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
